FILE: rtl/kway_sorted_run_merger_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted run merger
// Clocked, reset-qualified same-cycle and next-cycle implication checks.
// ---------------------------------------------------------------------------
`ifndef KWAY_SORTED_RUN_MERGER_DEFINES_SVH
`define KWAY_SORTED_RUN_MERGER_DEFINES_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define KSRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define KSRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ksrm_pkg.sv
// ---------------------------------------------------------------------------
// Sorted run merger package
// Sizes, register map, controller states and control bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ksrm_pkg;

  localparam int RUNS         = 16;
  localparam int RUN_W        = $clog2(RUNS);
  localparam int CNT_W        = RUN_W + 1;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [CNT_W-1:0]   RUN_COUNT_RESET = CNT_W'(RUNS);
  localparam logic [PADDR_W-1:0] ADDR_RUN_COUNT  = PADDR_W'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_FINISH
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;        // accept the input beat and update the run
    logic scan_start;  // rewind the head scan and drop the best candidate
    logic scan_step;   // read the next head slot
    logic load_tuple;  // move the winner into the output register
    logic load_done;   // emit the done beat and clear all runs
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic all_ended;
    logic heads_ready;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/kway_sorted_run_merger.sv
// ---------------------------------------------------------------------------
// K-way sorted run merger
// Merges up to sixteen ascending runs into one ascending stream of tuples.
// ---------------------------------------------------------------------------
// Each input beat refills the head slot of one run or marks that run ended.
// Once every live run holds a head, the smallest key is emitted (lowest run
// wins on equal keys) and its slot is emptied; when every run of the merge
// has ended a single beat with merge_done set and zero fields is emitted and
// all runs are cleared for the next merge. One beat is worked on at a time:
// for a beat that makes a tuple due, the heads of slots 0 to n-1, n being
// the effective run count, are read from the head memory one slot per
// cycle on its single read port. A finished beat waits in an output
// register, so the next input beat is taken while the previous result is
// still stalled. Heads that were never refilled read as garbage but are
// never chosen. run_count lives at byte address 0 of the APB port; 0 acts
// as 1 and values above 16 as 16.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kway_sorted_run_merger (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ksrm_pkg::PADDR_W-1:0]       paddr,
  input  logic [ksrm_pkg::PDATA_W-1:0]       pwdata,
  output logic [ksrm_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  // input beats
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ksrm_pkg::RUN_W-1:0]         run_index_i,
  input  logic [ksrm_pkg::KEY_BITS-1:0]      key_i,
  input  logic [ksrm_pkg::PAYLOAD_BITS-1:0]  payload_i,
  input  logic                               run_ended_i,
  // result beats
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ksrm_pkg::RUN_W-1:0]         out_run_o,
  output logic [ksrm_pkg::KEY_BITS-1:0]      out_key_o,
  output logic [ksrm_pkg::PAYLOAD_BITS-1:0]  out_payload_o,
  output logic                               merge_done_o
);

  logic [ksrm_pkg::CNT_W-1:0] run_count_q, run_count_d;
  logic                       cfg_wr;
  ksrm_pkg::ctrl_cmd_t        cmd;
  ksrm_pkg::dp_status_t       status;

  // APB: zero wait states, write on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ksrm_pkg::ADDR_RUN_COUNT);

  // Keep the raw 5-bit value; clamping happens where it is used.
  always_comb begin
    run_count_d = run_count_q;
    if (cfg_wr) run_count_d = pwdata[ksrm_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count_q <= ksrm_pkg::RUN_COUNT_RESET;
    end else begin
      run_count_q <= run_count_d;
    end
  end

  // Read back the register; other addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr == ksrm_pkg::ADDR_RUN_COUNT) begin
      prdata = ksrm_pkg::PDATA_W'(run_count_q);
    end
  end

  // Sequencer: accept, check, scan heads, emit.
  ksrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Head storage, run flags, minimum scan and output register.
  ksrm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .run_count_i   (run_count_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .run_index_i   (run_index_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .run_ended_i   (run_ended_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_run_o     (out_run_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .merge_done_o  (merge_done_o)
  );

endmodule

FILE: rtl/ksrm_dp.sv
// ---------------------------------------------------------------------------
// Sorted run merger datapath
// Head memories, run flags, sequential minimum scan and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kway_sorted_run_merger_defines.svh"

module ksrm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ksrm_pkg::CNT_W-1:0]        run_count_i,
  input  ksrm_pkg::ctrl_cmd_t               cmd_i,
  output ksrm_pkg::dp_status_t              status_o,
  input  logic [ksrm_pkg::RUN_W-1:0]        run_index_i,
  input  logic [ksrm_pkg::KEY_BITS-1:0]     key_i,
  input  logic [ksrm_pkg::PAYLOAD_BITS-1:0] payload_i,
  input  logic                              run_ended_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ksrm_pkg::RUN_W-1:0]        out_run_o,
  output logic [ksrm_pkg::KEY_BITS-1:0]     out_key_o,
  output logic [ksrm_pkg::PAYLOAD_BITS-1:0] out_payload_o,
  output logic                              merge_done_o
);

  logic [ksrm_pkg::KEY_BITS-1:0]     key_mem     [ksrm_pkg::RUNS];
  logic [ksrm_pkg::PAYLOAD_BITS-1:0] payload_mem [ksrm_pkg::RUNS];

  logic [ksrm_pkg::RUNS-1:0]  head_full_q, head_full_d;
  logic [ksrm_pkg::RUNS-1:0]  run_finished_q, run_finished_d;
  logic [ksrm_pkg::RUNS-1:0]  act_mask;
  logic [ksrm_pkg::CNT_W-1:0] n_eff;
  logic                       in_range;
  logic                       mem_wr;

  logic [ksrm_pkg::RUN_W-1:0]        scan_idx_q;
  logic [ksrm_pkg::RUN_W-1:0]        rd_idx_q;
  logic                              rd_vld_q;
  logic [ksrm_pkg::KEY_BITS-1:0]     rd_key_q;
  logic [ksrm_pkg::PAYLOAD_BITS-1:0] rd_payload_q;
  logic                              best_vld_q;
  logic [ksrm_pkg::RUN_W-1:0]        best_idx_q;
  logic [ksrm_pkg::KEY_BITS-1:0]     best_key_q;
  logic [ksrm_pkg::PAYLOAD_BITS-1:0] best_payload_q;
  logic                              best_upd;

  logic                              out_valid_q;
  logic [ksrm_pkg::RUN_W-1:0]        out_run_q;
  logic [ksrm_pkg::KEY_BITS-1:0]     out_key_q;
  logic [ksrm_pkg::PAYLOAD_BITS-1:0] out_payload_q;
  logic                              merge_done_q;

  // Clamp the run count into 1..RUNS.
  always_comb begin
    if (run_count_i == '0) begin
      n_eff = ksrm_pkg::CNT_W'(1);
    end else if (run_count_i > ksrm_pkg::CNT_W'(ksrm_pkg::RUNS)) begin
      n_eff = ksrm_pkg::CNT_W'(ksrm_pkg::RUNS);
    end else begin
      n_eff = run_count_i;
    end
  end

  always_comb begin
    for (int i = 0; i < ksrm_pkg::RUNS; i++) begin
      act_mask[i] = (ksrm_pkg::CNT_W'(i) < n_eff);
    end
  end

  assign in_range = ({1'b0, run_index_i} < n_eff);
  assign mem_wr   = cmd_i.take && in_range && !run_ended_i && !run_finished_q[run_index_i];

  // Run flags.
  always_comb begin
    head_full_d    = head_full_q;
    run_finished_d = run_finished_q;
    if (cmd_i.take && in_range) begin
      if (run_ended_i) begin
        run_finished_d[run_index_i] = 1'b1;
        head_full_d[run_index_i]    = 1'b0;
      end else if (!run_finished_q[run_index_i]) begin
        head_full_d[run_index_i] = 1'b1;
      end
    end
    if (cmd_i.load_tuple) begin
      head_full_d[best_idx_q] = 1'b0;
    end
    if (cmd_i.load_done) begin
      head_full_d    = '0;
      run_finished_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_full_q    <= '0;
      run_finished_q <= '0;
    end else begin
      head_full_q    <= head_full_d;
      run_finished_q <= run_finished_d;
    end
  end

  // Head memories: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      key_mem[run_index_i]     <= key_i;
      payload_mem[run_index_i] <= payload_i;
    end
    if (cmd_i.scan_step) begin
      rd_key_q     <= key_mem[scan_idx_q];
      rd_payload_q <= payload_mem[scan_idx_q];
    end
  end

  // Strict less-than in ascending order keeps the lowest run on ties.
  assign best_upd = rd_vld_q && head_full_q[rd_idx_q] &&
                    (!best_vld_q || (rd_key_q < best_key_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      best_idx_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        best_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + ksrm_pkg::RUN_W'(1);
        rd_idx_q   <= scan_idx_q;
      end
      if (best_upd) begin
        best_vld_q <= 1'b1;
        best_idx_q <= rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (best_upd) begin
      best_key_q     <= rd_key_q;
      best_payload_q <= rd_payload_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_tuple || cmd_i.load_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tuple) begin
      out_run_q     <= best_idx_q;
      out_key_q     <= best_key_q;
      out_payload_q <= best_payload_q;
      merge_done_q  <= 1'b0;
    end else if (cmd_i.load_done) begin
      out_run_q     <= '0;
      out_key_q     <= '0;
      out_payload_q <= '0;
      merge_done_q  <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_run_o     = out_run_q;
  assign out_key_o     = out_key_q;
  assign out_payload_o = out_payload_q;
  assign merge_done_o  = merge_done_q;

  assign status_o.all_ended   = &(run_finished_q | ~act_mask);
  assign status_o.heads_ready = &(run_finished_q | head_full_q | ~act_mask);
  assign status_o.scan_last   = ({1'b0, scan_idx_q} == (n_eff - ksrm_pkg::CNT_W'(1)));
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  `KSRM_ASSERT_IMP(a_full_xor_finished, clk_i, rst_ni, 1'b1,
                   ((head_full_q & run_finished_q) == '0), "run both full and finished")
  `KSRM_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, (cmd_i.load_tuple || cmd_i.load_done),
                   status_o.out_free, "output overwritten while held")
  `KSRM_ASSERT_IMP(a_winner_exists, clk_i, rst_ni, cmd_i.load_tuple,
                   (best_vld_q && head_full_q[best_idx_q]), "emit without a full winner")
  `KSRM_ASSERT_NXT(a_done_clears, clk_i, rst_ni, cmd_i.load_done,
                   (head_full_q == '0 && run_finished_q == '0), "runs not cleared after done")

endmodule

FILE: rtl/ksrm_ctrl.sv
// ---------------------------------------------------------------------------
// Sorted run merger controller
// Sequences accept, readiness check, head scan and result emission.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksrm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ksrm_pkg::dp_status_t status_i,
  output ksrm_pkg::ctrl_cmd_t  cmd_o
);

  ksrm_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ksrm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ksrm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ksrm_pkg::ST_CHECK;
      end
      ksrm_pkg::ST_CHECK: begin
        priority if (status_i.all_ended) begin
          state_d = ksrm_pkg::ST_FINISH;
        end else if (status_i.heads_ready) begin
          state_d = ksrm_pkg::ST_SCAN;
        end else begin
          state_d = ksrm_pkg::ST_IDLE;
        end
      end
      ksrm_pkg::ST_SCAN: begin
        if (status_i.scan_last) state_d = ksrm_pkg::ST_DRAIN;
      end
      ksrm_pkg::ST_DRAIN: begin
        state_d = ksrm_pkg::ST_EMIT;
      end
      ksrm_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = ksrm_pkg::ST_IDLE;
      end
      ksrm_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = ksrm_pkg::ST_IDLE;
      end
      default: begin
        state_d = ksrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ksrm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      ksrm_pkg::ST_CHECK: begin
        cmd_o.scan_start = !status_i.all_ended && status_i.heads_ready;
      end
      ksrm_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ksrm_pkg::ST_DRAIN: begin
        cmd_o = '0;
      end
      ksrm_pkg::ST_EMIT: begin
        cmd_o.load_tuple = status_i.out_free;
      end
      ksrm_pkg::ST_FINISH: begin
        cmd_o.load_done = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: sim/kway_sorted_run_merger_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the k-way sorted run merger
// Drives refill and end-mark beats, predicts every emitted tuple and done
// beat, and checks each result beat field by field in arrival order.
// ---------------------------------------------------------------------------
// A directed opening covers key and payload extremes, equal-key ties, refills
// of full slots and of ended runs, end marks on full slots, run indexes past
// the run count and a finished merge. Random phases then run whole merges at
// several run counts (the out-of-range settings included), mostly as
// well-formed refills of empty live runs with some noise beats mixed in,
// under different patterns of sender gaps and receiver stall. One phase
// holds the result side off for a long stretch so that the block backs up
// and stalls its input.
// ---------------------------------------------------------------------------

module kway_sorted_run_merger_tb;

  localparam int CLK_HALF      = 5;
  // covers the slowest beat (16 heads read one per cycle) with plenty spare
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;

  typedef struct packed {
    logic [ksrm_pkg::RUN_W-1:0]        run;
    logic [ksrm_pkg::KEY_BITS-1:0]     key;
    logic [ksrm_pkg::PAYLOAD_BITS-1:0] payload;
    logic                              ended;
  } refill_beat_t;

  typedef struct packed {
    logic [ksrm_pkg::RUN_W-1:0]        run;
    logic [ksrm_pkg::KEY_BITS-1:0]     key;
    logic [ksrm_pkg::PAYLOAD_BITS-1:0] payload;
    logic                              done;
  } emit_beat_t;

  // -------------------------------------------------------------------------
  // Merge predictor: mirrors the heads of every run and queues the beats the
  // block must emit, oldest first.
  // -------------------------------------------------------------------------
  class merge_order_model;
    logic [ksrm_pkg::CNT_W-1:0]        run_count;
    logic [ksrm_pkg::KEY_BITS-1:0]     head_key [ksrm_pkg::RUNS];
    logic [ksrm_pkg::PAYLOAD_BITS-1:0] head_payload [ksrm_pkg::RUNS];
    bit                                head_full [ksrm_pkg::RUNS];
    bit                                run_finished [ksrm_pkg::RUNS];
    emit_beat_t                        pending_emits [$];
    int                                errors;

    function new();
      run_count = ksrm_pkg::RUN_COUNT_RESET;
      errors    = 0;
      clear_runs();
    endfunction

    function void clear_runs();
      for (int i = 0; i < ksrm_pkg::RUNS; i++) begin
        head_key[i]     = '0;
        head_payload[i] = '0;
        head_full[i]    = 1'b0;
        run_finished[i] = 1'b0;
      end
    endfunction

    // 0 behaves as one run, anything past RUNS as RUNS
    function int live_runs();
      if (run_count == 0) return 1;
      if (run_count > ksrm_pkg::RUNS) return ksrm_pkg::RUNS;
      return int'(run_count);
    endfunction

    function void note_beat(refill_beat_t b);
      int         n;
      int         win;
      bit         all_ended;
      bit         heads_ready;
      emit_beat_t e;
      n           = live_runs();
      win         = -1;
      all_ended   = 1'b1;
      heads_ready = 1'b1;
      e           = '0;
      if (int'(b.run) < n) begin
        if (b.ended) begin
          run_finished[b.run] = 1'b1;
          head_full[b.run]    = 1'b0;
        end else if (!run_finished[b.run]) begin
          head_key[b.run]     = b.key;
          head_payload[b.run] = b.payload;
          head_full[b.run]    = 1'b1;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (!run_finished[i]) begin
          all_ended = 1'b0;
          if (!head_full[i]) heads_ready = 1'b0;
        end
      end
      if (all_ended) begin
        e.done = 1'b1;
        pending_emits = {pending_emits, e};
        clear_runs();
        return;
      end
      if (!heads_ready) return;
      // strict less-than: the lowest run keeps an equal key
      for (int i = 0; i < n; i++) begin
        if (head_full[i] && (win < 0 || head_key[i] < head_key[win])) win = i;
      end
      if (win < 0) return;
      e.run          = ksrm_pkg::RUN_W'(win);
      e.key          = head_key[win];
      e.payload      = head_payload[win];
      head_full[win] = 1'b0;
      pending_emits  = {pending_emits, e};
    endfunction

    function void report_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_emit(emit_beat_t got);
      emit_beat_t want;
      if (pending_emits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual run %0d key %h payload %h done %b",
                 $time, got.run, got.key, got.payload, got.done);
        errors++;
        return;
      end
      want = pending_emits.pop_front();
      report_field("out_run", 64'(want.run), 64'(got.run));
      report_field("out_key", 64'(want.key), 64'(got.key));
      report_field("out_payload", 64'(want.payload), 64'(got.payload));
      report_field("merge_done", 64'(want.done), 64'(got.done));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Block signals, every input driven to a known value from time zero
  // -------------------------------------------------------------------------
  logic                              clk           = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              psel          = 1'b0;
  logic                              penable       = 1'b0;
  logic                              pwrite        = 1'b0;
  logic [ksrm_pkg::PADDR_W-1:0]      paddr         = '0;
  logic [ksrm_pkg::PDATA_W-1:0]      pwdata        = '0;
  logic [ksrm_pkg::PDATA_W-1:0]      prdata;
  logic                              pready;
  logic                              in_valid_i    = 1'b0;
  logic                              in_stall_o;
  logic [ksrm_pkg::RUN_W-1:0]        run_index_i   = '0;
  logic [ksrm_pkg::KEY_BITS-1:0]     key_i         = '0;
  logic [ksrm_pkg::PAYLOAD_BITS-1:0] payload_i     = '0;
  logic                              run_ended_i   = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i   = 1'b0;
  logic [ksrm_pkg::RUN_W-1:0]        out_run_o;
  logic [ksrm_pkg::KEY_BITS-1:0]     out_key_o;
  logic [ksrm_pkg::PAYLOAD_BITS-1:0] out_payload_o;
  logic                              merge_done_o;

  merge_order_model model;
  emit_beat_t       seen_emit;

  // idling knobs, changed only between phases while the block is idle
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  // a long hold-off is requested by bumping this; the stall process counts it
  int hold_requests   = 0;
  int hold_served     = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  kway_sorted_run_merger i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .run_index_i   (run_index_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .run_ended_i   (run_ended_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_run_o     (out_run_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .merge_done_o  (merge_done_o)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Result side: stall at random, or hold off for a long stretch on request.
  // Change at the falling edge only.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  // Sample result beats at the rising edge and hand them to the predictor.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen_emit.run     = out_run_o;
      seen_emit.key     = out_key_o;
      seen_emit.payload = out_payload_o;
      seen_emit.done    = merge_done_o;
      model.check_emit(seen_emit);
    end
  end

  // Watchdog: give up once no beat has moved on either side for too long.
  always @(posedge clk) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("kway_sorted_run_merger_tb NOT OK");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------
  // Offer one beat and hold it until the block takes it. Valid stays high
  // after the beat; the next call or the drain changes it at the next falling
  // edge, before the block can sample it again.
  task automatic send_beat(input int run, input logic [ksrm_pkg::KEY_BITS-1:0] key,
                           input logic [ksrm_pkg::PAYLOAD_BITS-1:0] payload,
                           input bit ended);
    refill_beat_t b;
    b.run     = ksrm_pkg::RUN_W'(run);
    b.key     = key;
    b.payload = payload;
    b.ended   = ended;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk);
    end
    run_index_i = b.run;
    key_i       = b.key;
    payload_i   = b.payload;
    run_ended_i = b.ended;
    in_valid_i  = 1'b1;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    model.note_beat(b);
  endtask

  // Mostly refill or end an empty live run, so that merges keep progressing;
  // otherwise send noise to any run index.
  task automatic send_random_beat();
    int n;
    int run;
    bit ended;
    int empty_runs [$];
    n = model.live_runs();
    for (int i = 0; i < n; i++) begin
      if (!model.run_finished[i] && !model.head_full[i]) empty_runs = {empty_runs, i};
    end
    if (empty_runs.size() > 0 && $urandom_range(99) < 85) begin
      run   = empty_runs[$urandom_range(empty_runs.size() - 1)];
      ended = ($urandom_range(7) == 0);
    end else begin
      run   = $urandom_range(ksrm_pkg::RUNS - 1);
      ended = ($urandom_range(3) == 0);
    end
    // small keys now and then to force ties between runs
    send_beat(run,
              ($urandom_range(2) == 0) ? ksrm_pkg::KEY_BITS'($urandom_range(7)) : $urandom,
              $urandom, ended);
  endtask

  // Drop valid, wait for every predicted beat, then let the block finish any
  // beat that causes no result.
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (model.pending_emits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write run_count over the APB port and read it back; call only when idle.
  task automatic program_run_count(input int value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ksrm_pkg::ADDR_RUN_COUNT;
    pwdata  = ksrm_pkg::PDATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    model.run_count = ksrm_pkg::CNT_W'(value);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== ksrm_pkg::PDATA_W'(model.run_count)) begin
      $display("%0t: run_count read-back mismatch, expected %h, actual %h",
               $time, ksrm_pkg::PDATA_W'(model.run_count), prdata);
      model.errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic run_phase(input int count, input int s_idle, input int r_stall,
                           input int beats, input bit squeeze);
    drain_and_settle();
    program_run_count(count);
    sender_idle_pct = s_idle;
    stall_pct       = r_stall;
    if (squeeze) hold_requests++;
    repeat (beats) send_random_beat();
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    model = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Directed part on a three-run merge.
    program_run_count(3);
    send_beat(0, '0, '0, 1'b0);
    send_beat(1, '1, '1, 1'b0);
    send_beat(2, '0, 32'h5, 1'b0);               // ready: tie on zero, run 0 wins
    send_beat(0, '0, 32'h1, 1'b0);               // tie again against run 2
    send_beat(0, 32'h7, 32'h2, 1'b0);            // run 2 goes out
    send_beat(0, 32'h9, 32'h3, 1'b0);            // refill of a full slot replaces it
    send_beat(5, 32'h1, 32'h4, 1'b0);            // run past the count: dropped
    send_beat(2, '1, '1, 1'b1);                  // end run 2, run 0 emits
    send_beat(2, 32'h3, 32'h6, 1'b0);            // refill of an ended run: dropped
    send_beat(1, 32'h1234_5678, 32'h9, 1'b1);    // end mark discards the held head
    send_beat(0, 32'h8000_0000, 32'hA5A5_A5A5, 1'b0);
    send_beat(0, '0, '0, 1'b1);                  // last run ends: done beat
    send_beat(15, '1, '1, 1'b1);                 // end mark past the count
    send_beat(1, 32'hFFFF_FFFE, 32'h5A5A_5A5A, 1'b0);
    send_beat(0, '1, '0, 1'b0);
    send_beat(2, '1, 32'h7, 1'b0);               // run 1 holds the smallest key and wins

    // Random merges: count, sender idle %, receiver stall %, beats, hold-off.
    run_phase(16, 0, 0, 150, 1'b0);
    run_phase(1, 47, 0, 80, 1'b0);
    run_phase(0, 0, 47, 60, 1'b0);
    run_phase(31, 20, 20, 150, 1'b0);
    run_phase(2, 47, 0, 100, 1'b0);
    run_phase(5, 0, 47, 100, 1'b1);
    run_phase(17, 20, 20, 120, 1'b0);
    run_phase(4, 0, 0, 100, 1'b0);
    run_phase($urandom_range(31), 20, 20, 90, 1'b0);
    run_phase(8, 0, 0, 100, 1'b0);

    drain_and_settle();
    if (model.errors == 0 && model.pending_emits.size() == 0) begin
      $display("kway_sorted_run_merger_tb OK");
    end else begin
      $display("kway_sorted_run_merger_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ksrm_pkg.sv
rtl/ksrm_dp.sv
rtl/ksrm_ctrl.sv
rtl/kway_sorted_run_merger.sv
sim/kway_sorted_run_merger_tb.sv
